// File: hw/rtl/ircb_pkg.sv
// Shared types, constants and helper functions for the IPv4 range to CIDR unit.
// Used by ircb_ctrl, ircb_dp and ip_range_to_cidr_blocks_unit.
`default_nettype none

package ircb_pkg;

  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned PREFIX_W = 6;
  localparam int unsigned K_W      = 6;

  // Input word: one inclusive address range.
  typedef struct packed {
    logic [ADDR_W-1:0] range_start;
    logic [ADDR_W-1:0] range_end;
  } ircb_range_t;

  // Output word: one CIDR block.
  typedef struct packed {
    logic [ADDR_W-1:0]   block_base;
    logic [PREFIX_W-1:0] prefix_length;
    logic                last_block;
  } ircb_block_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic step;
  } ircb_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic done;
  } ircb_stat_t;

  // Count of trailing zero bits; a zero address counts as fully aligned.
  function automatic logic [K_W-1:0] trailing_zeros(input logic [ADDR_W-1:0] v);
    logic [K_W-1:0] r;
    r = K_W'(ADDR_W);
    for (int i = ADDR_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = K_W'(i);
      end
    end
    return r;
  endfunction

  // Index of the highest set bit of the remaining address count.
  function automatic logic [K_W-1:0] leading_one(input logic [ADDR_W:0] v);
    logic [K_W-1:0] r;
    r = '0;
    for (int i = 0; i <= ADDR_W; i++) begin
      if (v[i]) begin
        r = K_W'(i);
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/ip_range_to_cidr_blocks_unit.sv
// Top level of the IPv4 range to CIDR unit: ties the controller to the datapath.
// Depends on ircb_pkg, ircb_ctrl and ircb_dp.
`default_nettype none

// Usage:
// A range word (addr_range) is taken at a rising edge where start is high and
// busy is low. The unit then splits the inclusive range into the minimal
// ascending run of aligned CIDR blocks, one block a cycle, found by a
// trailing-zero count on the current address and a leading-one search on the
// remaining address count, both in the same cycle.
// Each block word appears on cidr_block for exactly one cycle, marked by
// cidr_valid; last_block marks the final word of the range. The receiver
// cannot stall the unit and must take every word as it appears.
// The accepting edge loads the walk state; the first step then fills the output
// word register, from which the first word appears on cidr_block.
// A range splits into 1 to 62 blocks and busy stays high while they are stepped
// out; a new range can be accepted in the cycle its last word is shown.
// A range whose start is above its end gives one /32 word at start.
// Reset (rst, synchronous) returns the unit to idle and drops cidr_valid.

module ip_range_to_cidr_blocks_unit (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire ircb_pkg::ircb_range_t addr_range,
  output logic                      cidr_valid,
  output ircb_pkg::ircb_block_t      cidr_block
);
  import ircb_pkg::*;

  ircb_cmd_t  cmd;
  ircb_stat_t stat;

  ircb_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .stat  (stat)
  );

  ircb_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .addr_range (addr_range),
    .cmd        (cmd),
    .stat       (stat),
    .cidr_valid (cidr_valid),
    .cidr_block (cidr_block)
  );

  // An accepted range starts a run.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted range did not start a run");

  // While running, a word comes out every cycle.
  a_busy_word: assert property (@(posedge clk) disable iff (rst)
    busy |=> cidr_valid)
    else $error("missing block word during a run");

  // The final word is shown once the unit is idle again.
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    cidr_valid && cidr_block.last_block |-> !busy)
    else $error("still busy after the final block");

  // A word that is not final means the run goes on.
  a_more_busy: assert property (@(posedge clk) disable iff (rst)
    cidr_valid && !cidr_block.last_block |-> busy)
    else $error("run ended without a final block");

endmodule

`default_nettype wire

// File: hw/rtl/ircb_ctrl.sv
// Controller state machine of the IPv4 range to CIDR unit.
// Depends on ircb_pkg for the command and status structs.
`default_nettype none

module ircb_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  output ircb_pkg::ircb_cmd_t      cmd,
  input  wire ircb_pkg::ircb_stat_t stat
);
  import ircb_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic state;
  logic state_next;

  // Next state: a range is loaded from idle, and the run ends on the final block.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (stat.done) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Commands to the datapath.
  always_comb begin
    cmd.load = (state == ST_IDLE) && start;
    cmd.step = (state == ST_RUN);
  end

  assign busy = (state == ST_RUN);

  // A load always leads into the run state.
  a_load_runs: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (state == ST_RUN))
    else $error("load did not enter the run state");

  // The run only ends on a finished step.
  a_end_on_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) && !stat.done |=> (state == ST_RUN))
    else $error("run ended before the final block");

  // Load and step never coincide.
  a_cmd_excl: assert property (@(posedge clk) disable iff (rst)
    !(cmd.load && cmd.step))
    else $error("load and step issued together");

endmodule

`default_nettype wire

// File: hw/rtl/ircb_dp.sv
// Datapath of the IPv4 range to CIDR unit: current address, remaining count,
// block search and the output register. Depends on ircb_pkg.
`default_nettype none

module ircb_dp (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire ircb_pkg::ircb_range_t addr_range,
  input  wire ircb_pkg::ircb_cmd_t   cmd,
  output ircb_pkg::ircb_stat_t       stat,
  output logic                      cidr_valid,
  output ircb_pkg::ircb_block_t      cidr_block
);
  import ircb_pkg::*;

  logic [ADDR_W-1:0] cur;
  logic [ADDR_W:0]   rem;
  logic              inverted;

  logic [ADDR_W:0]   diff;
  logic [K_W-1:0]    tz;
  logic [K_W-1:0]    lo;
  logic [K_W-1:0]    k;
  logic [ADDR_W:0]   size;
  logic              done;

  // End minus start; the borrow flags a range whose start is above its end.
  assign diff = {1'b0, addr_range.range_end} - {1'b0, addr_range.range_start};

  // Largest block: bounded by the alignment of cur and by the remaining count.
  always_comb begin
    tz   = trailing_zeros(cur);
    lo   = leading_one(rem);
    k    = (tz < lo) ? tz : lo;
    size = (ADDR_W + 1)'(1) << k;
    done = inverted || (rem == size);
  end

  assign stat.done = done;

  // Walk state: loaded from the range, advanced by one block a step.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur      <= addr_range.range_start;
      rem      <= {1'b0, diff[ADDR_W-1:0]} + (ADDR_W + 1)'(1);
      inverted <= diff[ADDR_W];
    end else if (cmd.step) begin
      cur <= cur + size[ADDR_W-1:0];
      rem <= rem - size;
    end
  end

  // Output word register.
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      cidr_block.block_base    <= cur;
      cidr_block.prefix_length <= inverted ? PREFIX_W'(ADDR_W) : PREFIX_W'(ADDR_W) - k;
      cidr_block.last_block    <= done;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cidr_valid <= 1'b0;
    end else begin
      cidr_valid <= cmd.step;
    end
  end

  // A block never runs past the end of the remaining count.
  a_fits: assert property (@(posedge clk) disable iff (rst)
    cmd.step && !inverted |-> (size <= rem))
    else $error("block exceeds remaining range");

  // Every word follows a step.
  a_word_after_step: assert property (@(posedge clk) disable iff (rst)
    cidr_valid |-> $past(cmd.step))
    else $error("word without a step");

  // A step never faces an empty remaining count.
  a_rem_nonzero: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> (rem != '0))
    else $error("step with nothing left to cover");

endmodule

`default_nettype wire

// File: dv/ircb_block_checker.sv
// Checker for the IPv4 range to CIDR unit: watches the range and block channels,
// predicts the block words of every accepted range and compares them in order.
// Depends on ircb_pkg for the range and block word types.
`timescale 1ns / 100ps

module ircb_block_checker (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  busy,
  input  ircb_pkg::ircb_range_t addr_range,
  input  logic                  cidr_valid,
  input  ircb_pkg::ircb_block_t cidr_block,
  output int                    mismatches,
  output int                    pending
);
  import ircb_pkg::*;

  // Block words still owed by the unit, oldest first.
  ircb_block_t expected_blocks[$];
  int          mismatch_count = 0;

  assign mismatches = mismatch_count;

  initial begin
    pending = 0;
  end

  // Appends one owed block word at the tail of the queue.
  task automatic enqueue_block(input ircb_block_t blk);
    expected_blocks.insert(expected_blocks.size(), blk);
  endtask

  // Splits one range into its ascending run of aligned blocks.
  task automatic queue_cidr_blocks(input ircb_range_t r);
    logic [63:0] cur;
    logic [63:0] last;
    logic [63:0] top;
    int          host_bits;
    bit          done;
    ircb_block_t blk;
    cur  = {32'd0, r.range_start};
    last = {32'd0, r.range_end};
    if (cur > last) begin
      // An inverted range yields a single host block at its start.
      blk.block_base    = r.range_start;
      blk.prefix_length = PREFIX_W'(ADDR_W);
      blk.last_block    = 1'b1;
      enqueue_block(blk);
    end else begin
      done = 1'b0;
      while (!done) begin
        // Grow the block while the address stays aligned and the block fits.
        host_bits = 0;
        while (host_bits < ADDR_W && cur[host_bits] == 1'b0 &&
               cur + (64'd1 << (host_bits + 1)) - 64'd1 <= last) begin
          host_bits++;
        end
        top = cur + (64'd1 << host_bits) - 64'd1;
        done = (top >= last);
        blk.block_base    = cur[ADDR_W-1:0];
        blk.prefix_length = PREFIX_W'(ADDR_W - host_bits);
        blk.last_block    = done;
        enqueue_block(blk);
        cur = top + 64'd1;
      end
    end
  endtask

  task automatic report_mismatch(input string field, input logic [ADDR_W-1:0] want,
                                 input logic [ADDR_W-1:0] got);
    $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
    mismatch_count++;
  endtask

  // Results are checked before a range accepted at the same edge is expanded.
  always @(posedge clk) begin
    ircb_block_t want;
    if (!rst) begin
      if (cidr_valid) begin
        if (expected_blocks.size() == 0) begin
          $display("%0t: unexpected block word, expected none, actual %h/%0d last %b",
                   $time, cidr_block.block_base, cidr_block.prefix_length,
                   cidr_block.last_block);
          mismatch_count++;
        end else begin
          want = expected_blocks.pop_front();
          if (cidr_block.block_base !== want.block_base) begin
            report_mismatch("block_base", want.block_base, cidr_block.block_base);
          end
          if (cidr_block.prefix_length !== want.prefix_length) begin
            report_mismatch("prefix_length", ADDR_W'(want.prefix_length),
                            ADDR_W'(cidr_block.prefix_length));
          end
          if (cidr_block.last_block !== want.last_block) begin
            report_mismatch("last_block", ADDR_W'(want.last_block),
                            ADDR_W'(cidr_block.last_block));
          end
        end
      end
      if (start && busy === 1'b0) begin
        queue_cidr_blocks(addr_range);
      end
    end
    pending <= expected_blocks.size();
  end

endmodule

// File: dv/tb_ip_range_to_cidr_blocks_unit.sv
// Testbench top for the IPv4 range to CIDR unit: drives directed and random
// ranges with random idle gaps and gives the verdict.
// Depends on ircb_pkg, ircb_block_checker and the unit itself.
`timescale 1ns / 100ps

module tb_ip_range_to_cidr_blocks_unit;
  import ircb_pkg::*;

  localparam int RANDOM_RANGES = 340;
  localparam int STALL_LIMIT   = 3000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  ircb_range_t addr_range = '0;
  logic        cidr_valid;
  ircb_block_t cidr_block;
  int          mismatches;
  int          pending;
  bit          idle_enabled = 1'b0;

  always #10 clk = ~clk;

  ip_range_to_cidr_blocks_unit DUT (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .addr_range (addr_range),
    .cidr_valid (cidr_valid),
    .cidr_block (cidr_block)
  );

  ircb_block_checker checker_inst (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .addr_range (addr_range),
    .cidr_valid (cidr_valid),
    .cidr_block (cidr_block),
    .mismatches (mismatches),
    .pending    (pending)
  );

  // Offers one range word and returns at the edge that accepts it.
  task automatic issue_range(input logic [31:0] first_addr, input logic [31:0] last_addr);
    int idle_cycles;
    idle_cycles = 0;
    if (idle_enabled) begin
      while ($urandom_range(99) < 26) begin
        idle_cycles++;
      end
    end
    @(negedge clk);
    if (idle_cycles > 0) begin
      start      <= 1'b0;
      addr_range <= {$urandom, $urandom};
      repeat (idle_cycles) @(negedge clk);
    end
    start      <= 1'b1;
    addr_range <= {first_addr, last_addr};
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  // Holds the sender off until every owed block word has come back.
  task automatic drain_blocks();
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Ends the run when neither channel moves for too long.
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((start && busy === 1'b0) || cidr_valid === 1'b1) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    logic [31:0] first_addr;
    logic [31:0] last_addr;
    logic [63:0] span;
    logic [63:0] sum;
    int          size_bits;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed ranges: whole space, the longest run, the halves, inverted ranges,
    // single addresses at both ends and a few typical subnets.
    issue_range(32'h0000_0000, 32'hFFFF_FFFF);
    issue_range(32'h0000_0001, 32'hFFFF_FFFE);
    issue_range(32'h0000_0000, 32'h7FFF_FFFF);
    issue_range(32'h8000_0000, 32'hFFFF_FFFF);
    issue_range(32'h0000_0000, 32'h0000_0000);
    issue_range(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    issue_range(32'hFFFF_FFFF, 32'h0000_0000);
    issue_range(32'h0000_0001, 32'h0000_0000);
    issue_range(32'h0000_0000, 32'hFFFF_FFFE);
    issue_range(32'h0000_0001, 32'hFFFF_FFFF);
    issue_range(32'h0A00_0000, 32'h0A00_00FF);
    issue_range(32'hC0A8_0001, 32'hC0A8_00FE);
    issue_range(32'hAAAA_AAAA, 32'h5555_5555);
    issue_range(32'h5555_5555, 32'hAAAA_AAAA);
    issue_range(32'h1234_5678, 32'h1234_5678);
    issue_range(32'h7FFF_FFFF, 32'h8000_0000);
    issue_range(32'hFFFF_FFFE, 32'hFFFF_FFFF);
    issue_range(32'h0000_0000, 32'h0000_0001);
    issue_range(32'hDEAD_BEEF, 32'hDEAD_BEEE);
    issue_range(32'h0000_0000, 32'h0000_FFFF);
    drain_blocks();

    // Random ranges, with a long stretch of back-to-back words in the middle.
    for (int n = 0; n < RANDOM_RANGES; n++) begin
      idle_enabled = !(n >= 130 && n < 210);
      if (n == 260) begin
        drain_blocks();
      end
      first_addr = $urandom;
      case ($urandom_range(99) / 10)
        0, 1, 2, 3: begin
          // Random start with a span of random magnitude, clipped at the top.
          size_bits = $urandom_range(32);
          span = {32'd0, $urandom} & ((64'd1 << size_bits) - 64'd1);
          sum = {32'd0, first_addr} + span;
          last_addr = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
        end
        4: begin
          // One exactly aligned block of random size.
          size_bits = $urandom_range(32);
          span = (64'd1 << size_bits) - 64'd1;
          first_addr = first_addr & ~span[31:0];
          last_addr = first_addr | span[31:0];
        end
        5, 6: begin
          // Fully random pair; about half come out inverted.
          last_addr = $urandom;
        end
        7: begin
          // Inverted on purpose.
          last_addr = (first_addr == 32'd0) ? 32'd0 : 32'($urandom_range(first_addr - 1));
          if (first_addr == 32'd0) begin
            first_addr = 32'd1;
          end
        end
        default: begin
          // Ragged edges near both ends of the space give long block runs.
          first_addr = 32'($urandom_range(255));
          last_addr  = 32'hFFFF_FFFF - 32'($urandom_range(255));
        end
      endcase
      issue_range(first_addr, last_addr);
    end

    drain_blocks();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/ircb_pkg.sv
hw/rtl/ircb_ctrl.sv
hw/rtl/ircb_dp.sv
hw/rtl/ip_range_to_cidr_blocks_unit.sv
dv/ircb_block_checker.sv
dv/tb_ip_range_to_cidr_blocks_unit.sv
